// ----- hdl/pfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int IDX_W      = 5;
    localparam int STEP_W     = 7;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LO_A    = 8'h61;

    // conversion selectors
    localparam logic [7:0] CONV_SDEC32 = 8'h64;  // d
    localparam logic [7:0] CONV_SDEC64 = 8'h44;  // D
    localparam logic [7:0] CONV_UDEC32 = 8'h75;  // u
    localparam logic [7:0] CONV_UDEC64 = 8'h55;  // U
    localparam logic [7:0] CONV_HEX32  = 8'h78;  // x
    localparam logic [7:0] CONV_HEX64  = 8'h58;  // X
    localparam logic [7:0] CONV_PTR    = 8'h70;  // p
    localparam logic [7:0] CONV_CHAR   = 8'h63;  // c

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [63:0] arg_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGITS,
        ST_CHAR2
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic hex;
    } t_unit_cmd;

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            digit_char = CH_ZERO + {4'b0, nib};
        end else begin
            digit_char = CH_LO_A + {4'b0, nib} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/printf_format_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Output: plain bytes, %c, %% and unknown conversions give their first char in the
// cycle after accept; decimal first runs the bit-serial double-dabble loop of the digit
// unit over the 32-bit (d/u) or 64-bit (D/U) argument, then steps through the digit
// positions, skipping leading zeros; hex steps through the nibbles likewise. Throughput:
// one plain byte per cycle unless output stalls; decimal/hex conversions hold the input.
// Reset: synchronous active-low i_rst_n clears the sequencer, pending-% flag, output valid.
module printf_format_engine import pfe_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  wire       i_stall,
    output t_out_word o_word
);

    t_state             r_state, n_state;
    logic               r_pend, n_pend;        // '%' seen, waiting for selector
    logic [7:0]         r_ch, n_ch;            // second char of an unknown conversion
    logic [IDX_W-1:0]   r_idx, n_idx;          // digit position being emitted
    logic [STEP_W-1:0]  r_steps, n_steps;      // double-dabble steps left
    logic               r_started, n_started;  // first significant digit out
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    t_unit_cmd          w_cmd;
    logic [63:0]        w_value;
    logic [3:0]         w_nib;
    logic               w_slot_free;
    logic               w_in_acc;
    logic [31:0]        w_neg_lo;
    logic [63:0]        w_neg_all;

    // output register frees up when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || !i_stall;
    assign o_stall     = !((r_state == ST_IDLE) && w_slot_free);
    assign w_in_acc    = i_valid && !o_stall;

    // magnitudes of negative args; wraparound gives the true value of the minimum
    assign w_neg_lo  = ~i_word.arg_value[31:0] + 32'd1;
    assign w_neg_all = ~i_word.arg_value + 64'd1;

    pfe_digit_unit u_unit (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (w_value),
        .i_idx   (r_idx),
        .o_nib   (w_nib)
    );

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_ch        = r_ch;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_cmd       = '0;
        w_value     = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (!r_pend) begin
                        if (i_word.fmt_char == CH_PERCENT) begin
                            n_pend = 1'b1;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out       = '{i_word.fmt_char, 1'b1};
                        end
                    end else begin
                        n_pend    = 1'b0;
                        n_started = 1'b0;
                        case (i_word.fmt_char)
                            CONV_SDEC32: begin
                                w_cmd.load = 1'b1;
                                n_steps    = STEP_W'(32);
                                n_idx      = IDX_W'(9);
                                n_state    = ST_CONV;
                                if (i_word.arg_value[31]) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{CH_MINUS, 1'b0};
                                    w_value     = {w_neg_lo, 32'b0};
                                end else begin
                                    w_value = {i_word.arg_value[31:0], 32'b0};
                                end
                            end
                            CONV_SDEC64: begin
                                w_cmd.load = 1'b1;
                                n_steps    = STEP_W'(64);
                                n_idx      = IDX_W'(NUM_DIGITS - 1);
                                n_state    = ST_CONV;
                                if (i_word.arg_value[63]) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{CH_MINUS, 1'b0};
                                    w_value     = w_neg_all;
                                end else begin
                                    w_value = i_word.arg_value;
                                end
                            end
                            CONV_UDEC32: begin
                                w_cmd.load = 1'b1;
                                w_value    = {i_word.arg_value[31:0], 32'b0};
                                n_steps    = STEP_W'(32);
                                n_idx      = IDX_W'(9);
                                n_state    = ST_CONV;
                            end
                            CONV_UDEC64: begin
                                w_cmd.load = 1'b1;
                                w_value    = i_word.arg_value;
                                n_steps    = STEP_W'(64);
                                n_idx      = IDX_W'(NUM_DIGITS - 1);
                                n_state    = ST_CONV;
                            end
                            CONV_HEX32: begin
                                w_cmd.load = 1'b1;
                                w_cmd.hex  = 1'b1;
                                w_value    = {32'b0, i_word.arg_value[31:0]};
                                n_idx      = IDX_W'(7);
                                n_state    = ST_DIGITS;
                            end
                            CONV_HEX64, CONV_PTR: begin
                                w_cmd.load = 1'b1;
                                w_cmd.hex  = 1'b1;
                                w_value    = i_word.arg_value;
                                n_idx      = IDX_W'(15);
                                n_state    = ST_DIGITS;
                            end
                            CONV_CHAR: begin
                                n_out_valid = 1'b1;
                                n_out       = '{i_word.arg_value[7:0], 1'b1};
                            end
                            CH_PERCENT: begin
                                n_out_valid = 1'b1;
                                n_out       = '{CH_PERCENT, 1'b1};
                            end
                            default: begin
                                // unknown selector: '%' now, the byte itself next
                                n_out_valid = 1'b1;
                                n_out       = '{CH_PERCENT, 1'b0};
                                n_ch        = i_word.fmt_char;
                                n_state     = ST_CHAR2;
                            end
                        endcase
                    end
                end
            end
            ST_CONV: begin
                w_cmd.step = 1'b1;
                n_steps    = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (!r_started && (w_nib == 4'd0) && (r_idx != '0)) begin
                    n_idx = r_idx - IDX_W'(1);   // leading zero, drop it
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{digit_char(w_nib), (r_idx == '0)};
                    n_started   = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            ST_CHAR2: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{r_ch, 1'b1};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_idx   <= n_idx;
        r_steps <= n_steps;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

`default_nettype wire

// ----- hdl/pfe_digit_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared shift / add-3 unit: one double-dabble step per cycle,
// digit readout by index.
module pfe_digit_unit import pfe_pkg::*; (
    input  wire              i_clk,
    input  t_unit_cmd        i_cmd,
    input  wire [63:0]       i_value,
    input  wire [IDX_W-1:0]  i_idx,
    output logic [3:0]       o_nib
);

    logic [NUM_DIGITS-1:0][3:0] r_bcd, n_bcd;
    logic [63:0]                r_bin, n_bin;
    logic [NUM_DIGITS-1:0][3:0] w_adj;
    logic [4*NUM_DIGITS-1:0]    w_adj_flat;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            w_adj[k] = (r_bcd[k] >= 4'd5) ? r_bcd[k] + 4'd3 : r_bcd[k];
        end
    end

    assign w_adj_flat = w_adj;

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_cmd.load) begin
            if (i_cmd.hex) begin
                n_bcd = {16'b0, i_value};
            end else begin
                n_bcd = '0;
                n_bin = i_value;
            end
        end else if (i_cmd.step) begin
            n_bcd = {w_adj_flat[4*NUM_DIGITS-2:0], r_bin[63]};
            n_bin = {r_bin[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_nib = r_bcd[i_idx];

endmodule

`default_nettype wire

// ----- hdl/pfe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfe_checker import pfe_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input t_in_word  i_word,
    input wire       o_valid,
    input wire       i_stall,
    input t_out_word o_word
);

    logic r_pend;
    logic w_acc;
    logic w_plain;
    logic w_arm;

    assign w_acc   = i_valid && !o_stall;
    assign w_plain = w_acc && !r_pend && (i_word.fmt_char != CH_PERCENT);
    assign w_arm   = w_acc && !r_pend && (i_word.fmt_char == CH_PERCENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_acc) begin
            r_pend <= !r_pend && (i_word.fmt_char == CH_PERCENT);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_word)))
        else $error("stalled output word changed");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output word blocked");

    a_plain_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_plain |=> (o_valid && o_word.last_of_run &&
                     (o_word.out_char == $past(i_word.fmt_char))))
        else $error("plain byte not copied out");

    a_percent_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_arm |=> !o_valid)
        else $error("percent produced output");

endmodule

bind printf_format_engine pfe_checker u_pfe_checker (.*);

`default_nettype wire
